FILE: rtl/core/lpht_pkg.sv
`default_nettype none

package lpht_pkg;

  // Slot store geometry; the field widths below are fixed by the item format.
  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned SIZE_W      = 5;
  localparam int unsigned KEY_W       = 8;
  localparam int unsigned HASH_W      = 16;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned HASH_CNT_W  = $clog2(HASH_W);

  // Task queue between front and back
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // One classified operation, ready for the probe walk
  typedef struct packed {
    logic              func;
    logic [KEY_W-1:0]  key;
    logic [IDX_W-1:0]  start;
    logic [SIZE_W-1:0] size;
  } task_t;

endpackage

`default_nettype wire

FILE: rtl/core/lpht_req_if.sv
`default_nettype none

interface lpht_req_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [lpht_pkg::KEY_W-1:0]    key;
  logic [lpht_pkg::HASH_W-1:0]   hash;

  modport source (output valid, output func, output key, output hash, input ready);
  modport sink   (input valid, input func, input key, input hash, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/lpht_rsp_if.sv
`default_nettype none

interface lpht_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [lpht_pkg::STATUS_W-1:0] status;
  logic [lpht_pkg::IDX_W-1:0]    slot;
  logic [lpht_pkg::SIZE_W-1:0]   probes;

  modport source (output valid, output status, output slot, output probes, input ready);
  modport sink   (input valid, input status, input slot, input probes, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/linear_probe_hash_table_unit.sv
`default_nettype none

// Channel   Dir  Handshake        Payload
// req_i     in   valid / ready    func, key, hash
// rsp_o     out  valid / ready    status, slot, probes
// cfg       in   cfg_we_i         cfg_wdata_i (table size)
//
// Front: accept, 16 remainder steps (hash mod size), then a queue push.
// Back: pop, then per probed slot a key store read and a check.
// Front and back overlap: the front can take a new request while the back walks the last one.
// Reset clears the slot-used flags at once; no clearing pass is needed.
// A result waiting in the output register stalls only the back once its next walk ends.
module linear_probe_hash_table_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [lpht_pkg::SIZE_W-1:0] cfg_wdata_i,
  lpht_req_if.sink                         req_i,
  lpht_rsp_if.source                       rsp_o
);

  logic [lpht_pkg::SIZE_W-1:0] table_size_q;
  logic [lpht_pkg::SIZE_W-1:0] active_size;
  logic                        push_valid, push_ready, pop_valid, pop_ready;
  lpht_pkg::task_t             push_task, pop_task;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= lpht_pkg::SIZE_W'(lpht_pkg::TABLE_DEPTH);
    end else if (cfg_we_i) begin
      table_size_q <= cfg_wdata_i;
    end
  end

  // Clamp size into 1 .. TABLE_DEPTH
  always_comb begin
    priority if (table_size_q == '0) begin
      active_size = lpht_pkg::SIZE_W'(1);
    end else if (table_size_q > lpht_pkg::SIZE_W'(lpht_pkg::TABLE_DEPTH)) begin
      active_size = lpht_pkg::SIZE_W'(lpht_pkg::TABLE_DEPTH);
    end else begin
      active_size = table_size_q;
    end
  end

  lpht_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .size_i       (active_size),
    .req_i        (req_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_task_o  (push_task)
  );

  lpht_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_task_i  (push_task),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_task_o   (pop_task)
  );

  lpht_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_task_i  (pop_task),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/lpht_front.sv
`default_nettype none

module lpht_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [lpht_pkg::SIZE_W-1:0] size_i,
  lpht_req_if.sink                         req_i,
  output logic                             push_valid_o,
  input  wire logic                        push_ready_i,
  output lpht_pkg::task_t                  push_task_o
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } front_state_e;

  front_state_e                    state_q, state_d;
  logic [lpht_pkg::HASH_CNT_W-1:0] cnt_q, cnt_d;
  logic [lpht_pkg::HASH_W-1:0]     hash_q, hash_d;
  logic [lpht_pkg::IDX_W-1:0]      rem_q, rem_d;
  logic [lpht_pkg::SIZE_W-1:0]     size_q, size_d;
  logic                            func_q, func_d;
  logic [lpht_pkg::KEY_W-1:0]      key_q, key_d;
  logic [lpht_pkg::SIZE_W-1:0]     shifted;

  assign req_i.ready  = (state_q == F_IDLE);
  assign push_valid_o = (state_q == F_PUSH);
  assign push_task_o  = '{func: func_q, key: key_q, start: rem_q, size: size_q};

  // Restoring remainder step: bring in one hash bit, subtract size if it fits
  assign shifted = {rem_q, hash_q[lpht_pkg::HASH_W-1]};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    hash_d  = hash_q;
    rem_d   = rem_q;
    size_d  = size_q;
    func_d  = func_q;
    key_d   = key_q;
    unique case (state_q)
      F_IDLE: begin
        if (req_i.valid) begin
          func_d  = req_i.func;
          key_d   = req_i.key;
          hash_d  = req_i.hash;
          size_d  = size_i;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = F_DIV;
        end
      end
      F_DIV: begin
        if (shifted >= size_q) begin
          rem_d = lpht_pkg::IDX_W'(shifted - size_q);
        end else begin
          rem_d = shifted[lpht_pkg::IDX_W-1:0];
        end
        hash_d = {hash_q[lpht_pkg::HASH_W-2:0], 1'b0};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == lpht_pkg::HASH_CNT_W'(lpht_pkg::HASH_W - 1)) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (push_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    hash_q <= hash_d;
    rem_q  <= rem_d;
    size_q <= size_d;
    func_q <= func_d;
    key_q  <= key_d;
  end

endmodule

`default_nettype wire

FILE: rtl/core/lpht_fifo.sv
`default_nettype none

module lpht_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire lpht_pkg::task_t  push_task_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output lpht_pkg::task_t       pop_task_o
);

  lpht_pkg::task_t                 entry_q [lpht_pkg::FIFO_DEPTH];
  logic [lpht_pkg::FIFO_PTR_W-1:0] wptr_q, rptr_q;
  logic [lpht_pkg::FIFO_CNT_W-1:0] cnt_q;
  logic                            push, pop;

  assign push_ready_o = (cnt_q != lpht_pkg::FIFO_CNT_W'(lpht_pkg::FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_task_o   = entry_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == lpht_pkg::FIFO_PTR_W'(lpht_pkg::FIFO_DEPTH - 1)) ? '0
                                                                              : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == lpht_pkg::FIFO_PTR_W'(lpht_pkg::FIFO_DEPTH - 1)) ? '0
                                                                              : rptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wptr_q] <= push_task_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/lpht_back.sv
`default_nettype none

module lpht_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             pop_valid_i,
  output logic                  pop_ready_o,
  input  wire lpht_pkg::task_t  pop_task_i,
  lpht_rsp_if.source            rsp_o
);

  typedef enum logic [2:0] {
    B_IDLE  = 3'b001,
    B_READ  = 3'b010,
    B_CHECK = 3'b100
  } back_state_e;

  back_state_e                   state_q, state_d;
  lpht_pkg::task_t               task_q, task_d;
  logic [lpht_pkg::IDX_W-1:0]    idx_q, idx_d;
  logic [lpht_pkg::SIZE_W-1:0]   pcnt_q, pcnt_d;
  logic [lpht_pkg::TABLE_DEPTH-1:0] used_q;
  logic [lpht_pkg::KEY_W-1:0]    key_mem [lpht_pkg::TABLE_DEPTH];
  logic [lpht_pkg::KEY_W-1:0]    rd_key_q;

  logic                          res_vld_q;
  lpht_pkg::status_e             res_status_q, res_status_d;
  logic [lpht_pkg::IDX_W-1:0]    res_slot_q, res_slot_d;
  logic [lpht_pkg::SIZE_W-1:0]   res_probes_q;

  logic slot_empty, key_hit, last_probe, done, out_free, finish, key_we;

  assign pop_ready_o = (state_q == B_IDLE);

  assign slot_empty = !used_q[idx_q];
  assign key_hit    = (task_q.func == lpht_pkg::FUNC_SEARCH) && (rd_key_q == task_q.key);
  assign last_probe = (pcnt_q == task_q.size);
  assign done       = slot_empty || key_hit || last_probe;
  assign out_free   = !res_vld_q || rsp_o.ready;
  assign finish     = (state_q == B_CHECK) && done && out_free;
  assign key_we     = finish && slot_empty && (task_q.func == lpht_pkg::FUNC_INSERT);

  always_comb begin
    priority if (slot_empty) begin
      if (task_q.func == lpht_pkg::FUNC_INSERT) begin
        res_status_d = lpht_pkg::ST_INSERTED;
        res_slot_d   = idx_q;
      end else begin
        res_status_d = lpht_pkg::ST_NOT_FOUND;
        res_slot_d   = '0;
      end
    end else if (key_hit) begin
      res_status_d = lpht_pkg::ST_FOUND;
      res_slot_d   = idx_q;
    end else begin
      // walked every slot in use
      res_status_d = (task_q.func == lpht_pkg::FUNC_INSERT) ? lpht_pkg::ST_FULL
                                                            : lpht_pkg::ST_NOT_FOUND;
      res_slot_d   = '0;
    end
  end

  always_comb begin
    state_d = state_q;
    task_d  = task_q;
    idx_d   = idx_q;
    pcnt_d  = pcnt_q;
    unique case (state_q)
      B_IDLE: begin
        if (pop_valid_i) begin
          task_d  = pop_task_i;
          idx_d   = pop_task_i.start;
          pcnt_d  = lpht_pkg::SIZE_W'(1);
          state_d = B_READ;
        end
      end
      B_READ: begin
        state_d = B_CHECK;
      end
      B_CHECK: begin
        if (!done) begin
          // advance with wrap at the active size
          idx_d   = ((lpht_pkg::SIZE_W'(idx_q) + 1'b1) == task_q.size) ? '0 : idx_q + 1'b1;
          pcnt_d  = pcnt_q + 1'b1;
          state_d = B_READ;
        end else if (out_free) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      used_q    <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (key_we) begin
        used_q[idx_q] <= 1'b1;
      end
      if (finish) begin
        res_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    task_q <= task_d;
    idx_q  <= idx_d;
    pcnt_q <= pcnt_d;
    if (finish) begin
      res_status_q <= res_status_d;
      res_slot_q   <= res_slot_d;
      res_probes_q <= pcnt_q;
    end
  end

  // Slot key store, registered read
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[idx_q] <= task_q.key;
    end
    rd_key_q <= key_mem[idx_q];
  end

  assign rsp_o.valid  = res_vld_q;
  assign rsp_o.status = res_status_q;
  assign rsp_o.slot   = res_slot_q;
  assign rsp_o.probes = res_probes_q;

endmodule

`default_nettype wire
